### hdl/hte_pkg.sv
// Package for the chained hash table engine.
// Holds the sizes, codes and payload types shared by the front end, queue, back end and top level; no dependencies.
`default_nettype none
package hte_pkg;
	localparam int MAX_BUCKETS = 256;
	localparam int POOL_NODES = 1024;
	localparam int BKT_W = $clog2(MAX_BUCKETS);
	localparam int CNT_W = $clog2(MAX_BUCKETS) + 1;
	localparam int IDX_W = $clog2(POOL_NODES);
	localparam int PTR_W = IDX_W + 1;
	localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_NODES);
	localparam int QUEUE_DEPTH = 2;
	localparam int DIV_BITS = 4;
	localparam int DIV_STEPS = 32 / DIV_BITS;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	// unused code: no table change, reports a miss
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [1:0] RES_OK = 2'd0;
	localparam logic [1:0] RES_MISS = 2'd1;
	localparam logic [1:0] RES_FULL = 2'd2;

	typedef struct packed {
		logic [1:0] operation;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0] outcome;
		logic signed [31:0] found_value;
	} rsp_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [31:0] key;
		logic [31:0] value;
		logic [BKT_W-1:0] bucket;
	} work_t;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] value;
		logic [PTR_W-1:0] link;
	} node_t;
endpackage
`default_nettype wire

### hdl/hte_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module hte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### hdl/hte_front.sv
// Front end: takes requests and works out the bucket, four quotient bits a cycle.
// Depends on hte_pkg.
`default_nettype none
module hte_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write,
	input wire logic [8:0] cfg_data,
	input wire logic req_valid,
	output logic req_ready,
	input wire hte_pkg::req_t req,
	output logic push,
	input wire logic push_ready,
	output hte_pkg::work_t push_data
);
	logic [hte_pkg::CNT_W-1:0] count_q;
	hte_pkg::req_t item_q;
	logic [31:0] div_q;
	logic [hte_pkg::CNT_W-1:0] rem_q;
	logic [$clog2(hte_pkg::DIV_STEPS)-1:0] step_q;
	logic busy_q;
	logic pend_q;
	logic [hte_pkg::CNT_W-1:0] rem_nx;
	logic [hte_pkg::CNT_W-1:0] cnt_sat;

	always_comb begin
		rem_nx = rem_q;
		for (int i = 0; i < hte_pkg::DIV_BITS; i++) begin
			rem_nx = {rem_nx[hte_pkg::CNT_W-2:0], div_q[31-i]};
			if (rem_nx >= count_q) begin
				rem_nx = rem_nx - count_q;
			end
		end
	end

	always_comb begin
		if (cfg_data == '0) begin
			cnt_sat = hte_pkg::CNT_W'(1);
		end else if (cfg_data > 9'(hte_pkg::MAX_BUCKETS)) begin
			cnt_sat = hte_pkg::CNT_W'(hte_pkg::MAX_BUCKETS);
		end else begin
			cnt_sat = hte_pkg::CNT_W'(cfg_data);
		end
	end

	assign req_ready = !busy_q && !pend_q;
	assign push = pend_q;
	assign push_data = '{operation: item_q.operation, key: item_q.key, value: item_q.value,
		bucket: rem_q[hte_pkg::BKT_W-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= hte_pkg::CNT_W'(16);
			busy_q <= 1'b0;
			pend_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (cfg_write) begin
				count_q <= cnt_sat;
			end
			if (req_valid && req_ready) begin
				item_q <= req;
				div_q <= req.key;
				rem_q <= '0;
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				div_q <= {div_q[31-hte_pkg::DIV_BITS:0], {hte_pkg::DIV_BITS{1'b0}}};
				rem_q <= rem_nx;
				step_q <= step_q + 1'b1;
				if (step_q == $bits(step_q)'(hte_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					pend_q <= 1'b1;
				end
			end else if (pend_q && push_ready) begin
				pend_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

### hdl/hte_queue.sv
// Short FIFO between the front end and the table walker.
// Depends on hte_pkg.
`default_nettype none
module hte_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic push_ready,
	input wire hte_pkg::work_t push_data,
	output logic pop_valid,
	input wire logic pop,
	output hte_pkg::work_t pop_data
);
	localparam int AW = $clog2(hte_pkg::QUEUE_DEPTH);
	hte_pkg::work_t slot_q [hte_pkg::QUEUE_DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0] fill_q;
	logic do_push;
	logic do_pop;

	assign push_ready = fill_q != (AW+1)'(hte_pkg::QUEUE_DEPTH);
	assign pop_valid = fill_q != '0;
	assign pop_data = slot_q[rd_q];
	assign do_push = push && push_ready;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(hte_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(hte_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			fill_q <= fill_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end
endmodule
`default_nettype wire

### hdl/hte_back.sv
// Back end: walks a bucket chain, edits nodes, the free list and bucket heads.
// Depends on hte_pkg and hte_ram.
`default_nettype none
module hte_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write,
	input wire logic pop_valid,
	output logic pop,
	input wire hte_pkg::work_t pop_data,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output hte_pkg::rsp_t rsp
);
	localparam int PW = hte_pkg::PTR_W;
	localparam int IW = hte_pkg::IDX_W;

	typedef enum logic [2:0] {
		S_IDLE, S_HEAD, S_NODE, S_ACT, S_ALLOC, S_DEL2, S_FIN
	} state_t;

	state_t state_q;
	hte_pkg::work_t item_q;
	logic [hte_pkg::MAX_BUCKETS-1:0] hvalid_q;
	logic [PW-1:0] fh_q;
	logic [PW-1:0] fc_q;
	logic [PW-1:0] cur_q;
	logic [PW-1:0] prev_q;
	logic [PW-1:0] head_q;
	hte_pkg::node_t cur_word_q;
	hte_pkg::node_t prev_word_q;
	logic hit_q;
	hte_pkg::rsp_t res_q;
	hte_pkg::rsp_t out_q;
	logic out_valid_q;

	logic head_we;
	logic [hte_pkg::BKT_W-1:0] head_raddr;
	logic [PW-1:0] head_wdata;
	logic [PW-1:0] head_rdata;
	logic [PW-1:0] head_ptr;
	logic node_we;
	logic [PW-1:0] node_waddr;
	logic [PW-1:0] node_raddr;
	hte_pkg::node_t node_wdata;
	hte_pkg::node_t node_rdata;
	logic [PW-1:0] next_free;

	hte_ram #(.WIDTH(PW), .DEPTH(hte_pkg::MAX_BUCKETS)) u_heads (
		.clk(clk), .we(head_we), .waddr(item_q.bucket), .wdata(head_wdata),
		.raddr(head_raddr), .rdata(head_rdata)
	);

	hte_ram #(.WIDTH($bits(hte_pkg::node_t)), .DEPTH(hte_pkg::POOL_NODES)) u_nodes (
		.clk(clk), .we(node_we), .waddr(node_waddr[IW-1:0]), .wdata(node_wdata),
		.raddr(node_raddr[IW-1:0]), .rdata(node_rdata)
	);

	assign head_raddr = pop_data.bucket;
	assign head_ptr = hvalid_q[item_q.bucket] ? head_rdata : hte_pkg::NIL;
	assign pop = (state_q == S_IDLE) && pop_valid;
	assign rsp_valid = out_valid_q;
	assign rsp = out_q;
	// a fresh node is always the fill count itself; its successor is the next one
	assign next_free = (fh_q == fc_q) ? PW'(fc_q + 1'b1) : node_rdata.link;

	always_comb begin
		unique case (state_q)
			S_HEAD: node_raddr = head_ptr;
			S_NODE: node_raddr = node_rdata.link;
			default: node_raddr = fh_q;
		endcase
	end

	always_comb begin
		head_we = 1'b0;
		head_wdata = fh_q;
		node_we = 1'b0;
		node_waddr = cur_q;
		node_wdata = cur_word_q;
		unique case (state_q)
			S_ACT: begin
				if (hit_q && item_q.operation == hte_pkg::OP_INSERT) begin
					node_we = 1'b1;
					node_wdata.value = item_q.value;
				end else if (hit_q && item_q.operation == hte_pkg::OP_DELETE) begin
					if (prev_q != hte_pkg::NIL) begin
						node_we = 1'b1;
						node_waddr = prev_q;
						node_wdata = prev_word_q;
						node_wdata.link = cur_word_q.link;
					end else begin
						head_we = 1'b1;
						head_wdata = cur_word_q.link;
					end
				end
			end
			S_ALLOC: begin
				head_we = 1'b1;
				head_wdata = fh_q;
				node_we = 1'b1;
				node_waddr = fh_q;
				node_wdata = '{key: item_q.key, value: item_q.value, link: head_q};
			end
			S_DEL2: begin
				node_we = 1'b1;
				node_wdata.link = fh_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hvalid_q <= '0;
			fh_q <= '0;
			fc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && (!out_valid_q || rsp_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_write) begin
				hvalid_q <= '0;
				fh_q <= '0;
				fc_q <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop_valid) begin
						item_q <= pop_data;
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					head_q <= head_ptr;
					cur_q <= head_ptr;
					prev_q <= hte_pkg::NIL;
					hit_q <= 1'b0;
					if (item_q.operation == hte_pkg::OP_NONE || head_ptr == hte_pkg::NIL) begin
						state_q <= S_ACT;
					end else begin
						state_q <= S_NODE;
					end
				end
				S_NODE: begin
					cur_word_q <= node_rdata;
					if (node_rdata.key == item_q.key) begin
						hit_q <= 1'b1;
						state_q <= S_ACT;
					end else begin
						prev_q <= cur_q;
						prev_word_q <= node_rdata;
						cur_q <= node_rdata.link;
						if (node_rdata.link == hte_pkg::NIL) begin
							state_q <= S_ACT;
						end
					end
				end
				S_ACT: begin
					unique case (item_q.operation)
						hte_pkg::OP_INSERT: begin
							if (hit_q) begin
								res_q <= '{outcome: hte_pkg::RES_OK, found_value: '0};
								state_q <= S_FIN;
							end else if (fh_q == hte_pkg::NIL) begin
								res_q <= '{outcome: hte_pkg::RES_FULL, found_value: '0};
								state_q <= S_FIN;
							end else begin
								res_q <= '{outcome: hte_pkg::RES_OK, found_value: '0};
								state_q <= S_ALLOC;
							end
						end
						hte_pkg::OP_SEARCH: begin
							if (hit_q) begin
								res_q <= '{outcome: hte_pkg::RES_OK,
									found_value: cur_word_q.value};
							end else begin
								res_q <= '{outcome: hte_pkg::RES_MISS, found_value: '0};
							end
							state_q <= S_FIN;
						end
						hte_pkg::OP_DELETE: begin
							if (hit_q) begin
								res_q <= '{outcome: hte_pkg::RES_OK, found_value: '0};
								state_q <= S_DEL2;
							end else begin
								res_q <= '{outcome: hte_pkg::RES_MISS, found_value: '0};
								state_q <= S_FIN;
							end
						end
						default: begin
							res_q <= '{outcome: hte_pkg::RES_MISS, found_value: '0};
							state_q <= S_FIN;
						end
					endcase
				end
				S_ALLOC: begin
					hvalid_q[item_q.bucket] <= 1'b1;
					fh_q <= next_free;
					if (fh_q == fc_q) begin
						fc_q <= PW'(fc_q + 1'b1);
					end
					state_q <= S_FIN;
				end
				S_DEL2: begin
					fh_q <= cur_q;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || rsp_ready) begin
						out_q <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### hdl/chained_hash_table_engine.sv
// Chained hash table engine, top level.
// Flow: the front end takes 8 remainder steps of 4 bits and pushes the item into the queue;
// the back end pops it, reads the bucket head, reads chain nodes up to a match, decides,
// passes through S_ALLOC for an insert of a new key into a free node or S_DEL2 for a delete
// that hits, and registers the result. The front end can divide while the back end is busy.
// Reset or a bucket_count write empties all chains at once via head valid bits and fill count.
`default_nettype none
module chained_hash_table_engine (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [8:0] cfg_data,
	input wire logic req_valid,
	output logic req_ready,
	input wire hte_pkg::req_t req,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output hte_pkg::rsp_t rsp
);
	logic cfg_write;
	logic push;
	logic push_ready;
	hte_pkg::work_t push_data;
	logic pop_valid;
	logic pop;
	hte_pkg::work_t pop_data;

	// user must send config only while idle, not enforced; every transfer is taken at once
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	// front: request transfer, bucket = key bits read unsigned, mod bucket_count
	hte_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.push(push), .push_ready(push_ready), .push_data(push_data)
	);

	// decouples the divider from the chain walker
	hte_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_ready(push_ready), .push_data(push_data),
		.pop_valid(pop_valid), .pop(pop), .pop_data(pop_data)
	);

	// back: chain walk, node edits, free list, response register
	hte_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_write),
		.pop_valid(pop_valid), .pop(pop), .pop_data(pop_data),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);
endmodule
`default_nettype wire
